### hw/rtl/omrs_pkg.sv
// Shared constants, codes and types of the move-to-front ordered list.
// No dependencies; used by the interfaces, the cell and the top level.
package omrs_pkg;

	localparam int CAPACITY = 1024;
	localparam int ITEM_W   = 10;
	localparam int RANK_W   = 10;
	localparam int ANS_W    = 10;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = ((CNT_W > RANK_W) ? CNT_W : RANK_W) + 1;

	localparam logic [2:0] KIND_LOAD   = 3'd0;
	localparam logic [2:0] KIND_TOP    = 3'd1;
	localparam logic [2:0] KIND_BOTTOM = 3'd2;
	localparam logic [2:0] KIND_SWAP   = 3'd3;
	localparam logic [2:0] KIND_RANK   = 3'd4;
	localparam logic [2:0] KIND_SELECT = 3'd5;

	localparam logic [1:0] OFS_NONE = 2'b00;
	localparam logic [1:0] OFS_NEXT = 2'b01;
	localparam logic [1:0] OFS_BAD  = 2'b10;
	localparam logic [1:0] OFS_PREV = 2'b11;

	typedef struct packed {
		logic               capture;
		logic [ITEM_W-1:0]  item;
		logic [CNT_W-1:0]   count;
		logic [IDX_W-1:0]   rank;
		logic               op_top;
		logic               op_bottom;
		logic               op_up;
		logic               op_down;
		logic               op_load;
	} omrs_bcast_t;

endpackage

### hw/rtl/omrs_if.sv
// Valid/ready channel interfaces for commands and responses.
// Depends on omrs_pkg for field widths.
interface omrs_cmd_if import omrs_pkg::*;;
	logic              valid;
	logic              ready;
	logic [2:0]        kind;
	logic [ITEM_W-1:0] item;
	logic signed [1:0] offset;
	logic [RANK_W-1:0] rank_index;

	modport source(output valid, output kind, output item, output offset,
		output rank_index, input ready);
	modport sink(input valid, input kind, input item, input offset,
		input rank_index, output ready);
endinterface

interface omrs_rsp_if import omrs_pkg::*;;
	logic             valid;
	logic             ready;
	logic [ANS_W-1:0] answer;
	logic             status;

	modport source(output valid, output answer, output status, input ready);
	modport sink(input valid, input answer, input status, output ready);
endinterface

### hw/rtl/omrs_cell.sv
// One rank slot of the list: holds an item, matches it against the command,
// and shifts or swaps with its neighbors. Depends on omrs_pkg.
module omrs_cell import omrs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [IDX_W-1:0]  idx,
	input  omrs_bcast_t       bcast,
	input  logic [ITEM_W-1:0] left_value,
	input  logic [ITEM_W-1:0] right_value,
	input  logic              left_match,
	input  logic              right_match,
	output logic [ITEM_W-1:0] value,
	output logic              match
);

	logic [ITEM_W-1:0] value_q;
	logic              match_q;
	logic [CNT_W-1:0]  pos;
	logic [CNT_W-1:0]  pos_next;
	logic [CNT_W-1:0]  rank_pos;
	logic              in_list;
	logic              is_last;
	logic              at_count;
	logic              at_or_after;
	logic              at_or_before;

	assign pos          = CNT_W'(idx);
	assign pos_next     = pos + CNT_W'(1);
	assign rank_pos     = CNT_W'(bcast.rank);
	assign in_list      = pos < bcast.count;
	assign is_last      = pos_next == bcast.count;
	assign at_count     = pos == bcast.count;
	assign at_or_after  = pos >= rank_pos;
	assign at_or_before = pos <= rank_pos;

	assign value = value_q;
	assign match = match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (bcast.capture) begin
			match_q <= in_list && (value_q == bcast.item);
		end
	end

	always_ff @(posedge clk) begin
		if (bcast.op_top && at_or_before) begin
			value_q <= left_value;
		end else if (bcast.op_bottom && at_or_after && in_list) begin
			value_q <= is_last ? bcast.item : right_value;
		end else if (bcast.op_up && match_q) begin
			value_q <= right_value;
		end else if (bcast.op_up && left_match) begin
			value_q <= bcast.item;
		end else if (bcast.op_down && match_q) begin
			value_q <= left_value;
		end else if (bcast.op_down && right_match) begin
			value_q <= bcast.item;
		end else if (bcast.op_load && at_count) begin
			value_q <= bcast.item;
		end
	end

endmodule

### hw/rtl/ordered_list_move_rank_select.sv
// Move-to-front ordered list built as a chain of rank cells.
// Cells match on acceptance and shift in ST_EXEC, where the response is registered.
// Commands are taken only in ST_IDLE while no response waits or it is being taken.
// Reset clears the item count, the match flags and the control state; cell items stay undefined.
// Depends on omrs_pkg, omrs_cmd_if, omrs_rsp_if and omrs_cell.
module ordered_list_move_rank_select import omrs_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	omrs_cmd_if.sink      cmd,
	omrs_rsp_if.source    rsp
);

	typedef enum logic {ST_IDLE, ST_EXEC} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic               rsp_valid_q;
	logic [ANS_W-1:0]   answer_q;
	logic               status_q;
	logic [2:0]         kind_s1;
	logic [ITEM_W-1:0]  item_s1;
	logic [1:0]         offset_s1;
	logic [RANK_W-1:0]  rank_index_s1;

	logic               accept;
	logic               known;
	logic [IDX_W-1:0]   rank;
	logic [CNT_W-1:0]   rank_cnt;
	logic [IDX_W-1:0]   sel_idx;
	logic               fail;
	logic [ANS_W-1:0]   answer_d;
	logic               op_top;
	logic               op_bottom;
	logic               op_up;
	logic               op_down;
	logic               op_load;
	logic               exec;
	omrs_bcast_t        bcast;

	logic [ITEM_W-1:0]  value_vec [CAPACITY];
	logic [CAPACITY-1:0] match_vec;

	assign cmd.ready  = (state_q == ST_IDLE) && (!rsp_valid_q || rsp.ready);
	assign accept     = cmd.valid && cmd.ready;
	assign rsp.valid  = rsp_valid_q;
	assign rsp.answer = answer_q;
	assign rsp.status = status_q;
	assign exec       = state_q == ST_EXEC;

	assign bcast.capture   = accept;
	assign bcast.item      = exec ? item_s1 : cmd.item;
	assign bcast.count     = count_q;
	assign bcast.rank      = rank;
	assign bcast.op_top    = op_top;
	assign bcast.op_bottom = op_bottom;
	assign bcast.op_up     = op_up;
	assign bcast.op_down   = op_down;
	assign bcast.op_load   = op_load;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ITEM_W-1:0] left_value;
		logic [ITEM_W-1:0] right_value;
		logic              left_match;
		logic              right_match;

		if (i == 0) begin : g_first
			assign left_value = item_s1;
			assign left_match = 1'b0;
		end else begin : g_mid_l
			assign left_value = value_vec[i-1];
			assign left_match = match_vec[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_value = item_s1;
			assign right_match = 1'b0;
		end else begin : g_mid_r
			assign right_value = value_vec[i+1];
			assign right_match = match_vec[i+1];
		end

		omrs_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.idx         (IDX_W'(i)),
			.bcast       (bcast),
			.left_value  (left_value),
			.right_value (right_value),
			.left_match  (left_match),
			.right_match (right_match),
			.value       (value_vec[i]),
			.match       (match_vec[i])
		);
	end

	always_comb begin
		rank = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (match_vec[i]) begin
				rank = rank | IDX_W'(i);
			end
		end
	end

	assign known    = |match_vec;
	assign rank_cnt = CNT_W'(rank);
	assign sel_idx  = IDX_W'(rank_index_s1);

	always_comb begin
		fail      = 1'b0;
		answer_d  = '0;
		op_top    = 1'b0;
		op_bottom = 1'b0;
		op_up     = 1'b0;
		op_down   = 1'b0;
		op_load   = 1'b0;
		case (kind_s1)
			KIND_LOAD: begin
				fail    = known || (count_q == CNT_W'(CAPACITY));
				op_load = !fail;
			end
			KIND_TOP: begin
				fail   = !known;
				op_top = !fail;
			end
			KIND_BOTTOM: begin
				fail      = !known;
				op_bottom = !fail;
			end
			KIND_SWAP: begin
				case (offset_s1)
					OFS_NONE: fail = 1'b0;
					OFS_NEXT: begin
						fail  = !known || ((rank_cnt + CNT_W'(1)) >= count_q);
						op_up = !fail;
					end
					OFS_PREV: begin
						fail    = !known || (rank == '0);
						op_down = !fail;
					end
					default: fail = 1'b1;
				endcase
			end
			KIND_RANK: begin
				fail     = !known;
				answer_d = ANS_W'(rank);
			end
			KIND_SELECT: begin
				fail     = !(CMP_W'(rank_index_s1) < CMP_W'(count_q));
				answer_d = ANS_W'(value_vec[sel_idx]);
			end
			default: fail = 1'b1;
		endcase
		if (fail || !exec) begin
			answer_d = '0;
		end
		if (!exec) begin
			op_top    = 1'b0;
			op_bottom = 1'b0;
			op_up     = 1'b0;
			op_down   = 1'b0;
			op_load   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			answer_q    <= '0;
			status_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (rsp_valid_q && rsp.ready) begin
						rsp_valid_q <= 1'b0;
					end
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					rsp_valid_q <= 1'b1;
					answer_q    <= answer_d;
					status_q    <= fail;
					if (op_load) begin
						count_q <= count_q + CNT_W'(1);
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1       <= cmd.kind;
			item_s1       <= cmd.item;
			offset_s1     <= cmd.offset;
			rank_index_s1 <= cmd.rank_index;
		end
	end

	a_exec_responds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) |=> rsp_valid_q)
		else $error("response missing after execute cycle");

	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) |-> $onehot0(match_vec))
		else $error("item found at more than one rank");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(count_q) <= CMP_W'(CAPACITY))
		else $error("item count beyond capacity");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EXEC) && !rsp_valid_q)
		else $error("transaction accepted without entering execute");

endmodule

### tb/tb_ordered_list_move_rank_select.sv
`timescale 1ns / 100ps
// Self-checking testbench for the move-to-front ordered list: predicts every response
// from its own copy of the rank and position stores. Depends on omrs_pkg, omrs_cmd_if,
// omrs_rsp_if and ordered_list_move_rank_select.
module tb_ordered_list_move_rank_select;
	import omrs_pkg::*;

	localparam int ITEM_SPACE  = 1 << ITEM_W;
	localparam int GEN_FULL    = (CAPACITY < ITEM_SPACE) ? CAPACITY : ITEM_SPACE;
	localparam int PHASE_ITEMS = 625;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;

	localparam logic [2:0] KIND_SPARE_LO = 3'd6;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;
	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_REFUSED = 1'b1;

	typedef struct packed {
		logic [2:0]        kind;
		logic [ITEM_W-1:0] item;
		logic [1:0]        offset;
		logic [RANK_W-1:0] rank_index;
	} list_cmd_t;

	typedef struct packed {
		logic [ANS_W-1:0] answer;
		logic             status;
	} list_rsp_t;

	logic clk;
	logic arst_n;

	omrs_cmd_if cmd_bus();
	omrs_rsp_if rsp_bus();

	ordered_list_move_rank_select DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.rsp    (rsp_bus)
	);

	// predicted list contents
	logic [ITEM_W-1:0] rank_to_item [CAPACITY];
	logic [IDX_W-1:0]  item_to_rank [ITEM_SPACE];
	int                list_len;

	// stimulus-side view of which items are in the list
	bit                gen_loaded [ITEM_SPACE];
	logic [ITEM_W-1:0] gen_pool [GEN_FULL];
	int                gen_len;
	int                queued;

	list_cmd_t cmd_queue [$];
	list_rsp_t answers_due [$];
	int        issued;
	int        answered;
	int        fail_count;
	int        send_idle_pct;
	int        recv_idle_pct;
	int        quiet_cycles;
	logic      cmd_took;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void place(input int rank, input logic [ITEM_W-1:0] it);
		rank_to_item[rank] = it;
		item_to_rank[it] = IDX_W'(rank);
	endfunction

	function automatic list_rsp_t apply_list_op(input list_cmd_t c);
		list_rsp_t r;
		logic [ITEM_W-1:0] other;
		logic present;
		int at;
		int i;
		r.answer = '0;
		r.status = STATUS_OK;
		at = int'(item_to_rank[c.item]);
		present = (at < list_len) && (rank_to_item[at] == c.item);
		case (c.kind)
			KIND_LOAD: begin
				if (present || list_len >= CAPACITY) begin
					r.status = STATUS_REFUSED;
				end else begin
					place(list_len, c.item);
					list_len = list_len + 1;
				end
			end
			KIND_TOP: begin
				if (!present) begin
					r.status = STATUS_REFUSED;
				end else begin
					for (i = at; i > 0; i--)
						place(i, rank_to_item[i-1]);
					place(0, c.item);
				end
			end
			KIND_BOTTOM: begin
				if (!present) begin
					r.status = STATUS_REFUSED;
				end else begin
					for (i = at; i + 1 < list_len; i++)
						place(i, rank_to_item[i+1]);
					place(list_len - 1, c.item);
				end
			end
			KIND_SWAP: begin
				case (c.offset)
					OFS_NONE: ;
					OFS_NEXT: begin
						if (!present || at + 1 >= list_len) begin
							r.status = STATUS_REFUSED;
						end else begin
							other = rank_to_item[at+1];
							place(at, other);
							place(at + 1, c.item);
						end
					end
					OFS_PREV: begin
						if (!present || at == 0) begin
							r.status = STATUS_REFUSED;
						end else begin
							other = rank_to_item[at-1];
							place(at, other);
							place(at - 1, c.item);
						end
					end
					default: r.status = STATUS_REFUSED;
				endcase
			end
			KIND_RANK: begin
				if (present)
					r.answer = ANS_W'(at);
				else
					r.status = STATUS_REFUSED;
			end
			KIND_SELECT: begin
				if (int'(c.rank_index) < list_len)
					r.answer = ANS_W'(rank_to_item[c.rank_index]);
				else
					r.status = STATUS_REFUSED;
			end
			default: r.status = STATUS_REFUSED;
		endcase
		return r;
	endfunction

	function automatic list_cmd_t random_cmd();
		list_cmd_t c;
		c.kind = 3'($urandom_range(7));
		c.item = ITEM_W'($urandom);
		c.offset = 2'($urandom);
		c.rank_index = RANK_W'($urandom);
		return c;
	endfunction

	function automatic list_cmd_t make_cmd(input logic [2:0] kind, input int it,
			input logic [1:0] ofs, input int rank);
		list_cmd_t c;
		c.kind = kind;
		c.item = ITEM_W'(it);
		c.offset = ofs;
		c.rank_index = RANK_W'(rank);
		return c;
	endfunction

	function automatic void enqueue_cmd(input list_cmd_t c);
		if (c.kind == KIND_LOAD && !gen_loaded[c.item] && gen_len < GEN_FULL) begin
			gen_loaded[c.item] = 1'b1;
			gen_pool[gen_len] = c.item;
			gen_len++;
		end
		cmd_queue.push_back(c);
		queued++;
	endfunction

	function automatic logic [ITEM_W-1:0] pick_known();
		return gen_pool[$urandom_range(gen_len - 1)];
	endfunction

	function automatic logic [ITEM_W-1:0] pick_fresh();
		int it;
		it = $urandom_range(ITEM_SPACE - 1);
		while (gen_loaded[it])
			it = (it + 1) % ITEM_SPACE;
		return ITEM_W'(it);
	endfunction

	// drive commands and response ready at the falling edge
	always @(negedge clk) begin : drive_cmd
		list_cmd_t pick;
		if (arst_n && (!cmd_bus.valid || cmd_took)) begin
			if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				pick = cmd_queue.pop_front();
				issued++;
				cmd_bus.valid <= 1'b1;
				cmd_bus.kind <= pick.kind;
				cmd_bus.item <= pick.item;
				cmd_bus.offset <= pick.offset;
				cmd_bus.rank_index <= pick.rank_index;
			end else begin
				cmd_bus.valid <= 1'b0;
			end
		end
		if (arst_n)
			rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// predict on each command transaction, check each response transaction
	always @(posedge clk) begin : check_rsp
		list_cmd_t got;
		list_rsp_t want;
		if (!arst_n) begin
			cmd_took <= 1'b0;
		end else begin
			cmd_took <= cmd_bus.valid && cmd_bus.ready;
			if (cmd_bus.valid && cmd_bus.ready) begin
				got.kind = cmd_bus.kind;
				got.item = cmd_bus.item;
				got.offset = cmd_bus.offset;
				got.rank_index = cmd_bus.rank_index;
				answers_due.push_back(apply_list_op(got));
			end
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (answers_due.size() == 0) begin
					$error("unexpected response: answer %0d status %0d",
						rsp_bus.answer, rsp_bus.status);
					fail_count++;
				end else begin
					want = answers_due.pop_front();
					answered++;
					if (rsp_bus.answer !== want.answer) begin
						$error("answer: expected %0d, actual %0d", want.answer, rsp_bus.answer);
						fail_count++;
					end
					if (rsp_bus.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, rsp_bus.status);
						fail_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_ordered_list_move_rank_select failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		list_cmd_t c;
		int roll;
		int sub;
		int target;
		int ph;
		int i;
		arst_n = 1'b0;
		cmd_bus.valid = 1'b0;
		cmd_bus.kind = KIND_LOAD;
		cmd_bus.item = '0;
		cmd_bus.offset = OFS_NONE;
		cmd_bus.rank_index = '0;
		rsp_bus.ready = 1'b0;
		cmd_took = 1'b0;
		quiet_cycles = 0;
		fail_count = 0;
		issued = 0;
		answered = 0;
		queued = 0;
		gen_len = 0;
		list_len = 0;
		for (i = 0; i < CAPACITY; i++)
			rank_to_item[i] = '0;
		for (i = 0; i < ITEM_SPACE; i++)
			item_to_rank[i] = '0;
		send_idle_pct = 36;
		recv_idle_pct = 48;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// empty list: all but load and a no-offset swap is refused; then directed loads, moves, swaps and queries
		enqueue_cmd(make_cmd(KIND_SELECT, 0, OFS_NONE, 0));
		enqueue_cmd(make_cmd(KIND_RANK, 7, OFS_NONE, 0));
		enqueue_cmd(make_cmd(KIND_TOP, 7, OFS_NONE, 0));
		enqueue_cmd(make_cmd(KIND_SWAP, 7, OFS_NONE, 0));
		enqueue_cmd(make_cmd(KIND_SWAP, 7, OFS_NEXT, 0));
		enqueue_cmd(make_cmd(KIND_SPARE_LO, 7, OFS_NONE, 0));
		enqueue_cmd(make_cmd(KIND_SPARE_HI, 1023, OFS_BAD, 1023));
		enqueue_cmd(make_cmd(KIND_LOAD, 0, OFS_NONE, 0));
		enqueue_cmd(make_cmd(KIND_LOAD, 1023, OFS_NONE, 0));
		enqueue_cmd(make_cmd(KIND_LOAD, 5, OFS_NONE, 0));
		enqueue_cmd(make_cmd(KIND_LOAD, 0, OFS_NONE, 0));
		enqueue_cmd(make_cmd(KIND_TOP, 1023, OFS_NONE, 0));
		enqueue_cmd(make_cmd(KIND_TOP, 1023, OFS_NONE, 0));
		enqueue_cmd(make_cmd(KIND_BOTTOM, 1023, OFS_NONE, 0));
		enqueue_cmd(make_cmd(KIND_BOTTOM, 1023, OFS_NONE, 0));
		enqueue_cmd(make_cmd(KIND_SWAP, 5, OFS_NEXT, 0));
		enqueue_cmd(make_cmd(KIND_SWAP, 5, OFS_NEXT, 0));
		enqueue_cmd(make_cmd(KIND_SWAP, 0, OFS_PREV, 0));
		enqueue_cmd(make_cmd(KIND_SWAP, 0, OFS_BAD, 0));
		enqueue_cmd(make_cmd(KIND_SWAP, 5, OFS_PREV, 0));
		enqueue_cmd(make_cmd(KIND_RANK, 1023, OFS_NONE, 0));
		enqueue_cmd(make_cmd(KIND_SELECT, 0, OFS_NONE, 0));
		enqueue_cmd(make_cmd(KIND_SELECT, 0, OFS_NONE, 2));
		enqueue_cmd(make_cmd(KIND_SELECT, 0, OFS_NONE, 3));
		enqueue_cmd(make_cmd(KIND_SELECT, 0, OFS_NONE, 1023));

		for (ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 48 : 0;
			recv_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 36 : 0;
			target = queued + PHASE_ITEMS;
			while (queued < target) begin
				c = random_cmd();
				roll = $urandom_range(99);
				if (gen_len == 0 || (gen_len < GEN_FULL && roll < 70)) begin
					c.kind = KIND_LOAD;
					c.item = (gen_len != 0 && $urandom_range(19) == 0) ? pick_known() : pick_fresh();
					enqueue_cmd(c);
				end else if (gen_len == GEN_FULL && roll < 8) begin
					c.kind = KIND_LOAD;
					enqueue_cmd(c);
				end else begin
					roll = $urandom_range(99);
					sub = $urandom_range(9);
					c.item = pick_known();
					if (roll < 13) begin
						enqueue_cmd(random_cmd());
					end else if (roll < 28) begin
						c.kind = KIND_TOP;
						enqueue_cmd(c);
						if (sub < 3) begin
							c.kind = (sub == 0) ? KIND_TOP : KIND_SWAP;
							c.offset = OFS_PREV;
							enqueue_cmd(c);
						end
					end else if (roll < 43) begin
						c.kind = KIND_BOTTOM;
						enqueue_cmd(c);
						if (sub < 3) begin
							c.kind = (sub == 0) ? KIND_BOTTOM : KIND_SWAP;
							c.offset = OFS_NEXT;
							enqueue_cmd(c);
						end
					end else if (roll < 63) begin
						c.kind = KIND_SWAP;
						c.offset = (sub < 4) ? OFS_PREV : (sub < 8) ? OFS_NEXT :
							(sub == 8) ? OFS_NONE : OFS_BAD;
						enqueue_cmd(c);
					end else if (roll < 80) begin
						c.kind = KIND_RANK;
						enqueue_cmd(c);
					end else begin
						c.kind = KIND_SELECT;
						if (sub < 8)
							c.rank_index = RANK_W'($urandom_range(gen_len - 1));
						else if (sub == 8 && gen_len < (1 << RANK_W))
							c.rank_index = RANK_W'(gen_len);
						enqueue_cmd(c);
					end
				end
			end
			while (cmd_queue.size() != 0 || answered != issued)
				@(negedge clk);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb_ordered_list_move_rank_select passed");
		else
			$display("tb_ordered_list_move_rank_select failed");
		$finish;
	end

endmodule
